FILE: rtl/core/lcp_echo_keepalive_assert.svh
// ----------------------------------------------------------------------------
// LCP echo keepalive assertion macros
// Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef LCP_ECHO_KEEPALIVE_ASSERT_SVH
`define LCP_ECHO_KEEPALIVE_ASSERT_SVH

// Checked only while out of reset
`define LCPEK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included
`define LCPEK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/lcpek_pkg.sv
// ----------------------------------------------------------------------------
// LCP echo keepalive package
// Word types, codes and register indexes shared by the keepalive block.
// ----------------------------------------------------------------------------
package lcpek_pkg;

  // Event kinds carried in the input word
  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_ECHO_REP = 2'd1,
    FUNC_ECHO_REQ = 2'd2,
    FUNC_UNUSED   = 2'd3
  } func_e;

  // Actions carried in the result word
  typedef enum logic [2:0] {
    ACT_NONE         = 3'd0,
    ACT_ECHO_REQ     = 3'd1,
    ACT_ECHO_REP     = 3'd2,
    ACT_CARRIER_LOST = 3'd3,
    ACT_LOOPBACK     = 3'd4
  } action_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ECHO_TIMEOUT  = 2'd0,
    CFG_FAILURE_LIMIT = 2'd1,
    CFG_LOCAL_MAGIC   = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [15:0] EchoTimeoutRst  = 16'd60;
  localparam logic [7:0]  FailureLimitRst = 8'd0;
  localparam logic [31:0] LocalMagicRst   = 32'd0;
  localparam logic [7:0]  OutstandingMax  = 8'hff;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_seconds;
    logic [31:0] rx_pkt_total;
    logic [31:0] reply_magic;
    logic        reply_has_magic;
    logic [7:0]  request_id;
  } lcpek_in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  packet_id;
    logic [31:0] magic_out;
  } lcpek_out_t;

  typedef struct packed {
    logic [15:0] echo_timeout;
    logic [7:0]  failure_limit;
    logic [31:0] local_magic;
  } lcpek_cfg_t;

  typedef struct packed {
    logic [31:0] last_rx_count;
    logic [31:0] last_activity_time;
    logic [7:0]  echoes_outstanding;
    logic [7:0]  next_id;
  } lcpek_state_t;

endpackage

FILE: rtl/core/lcpek_decide.sv
// ----------------------------------------------------------------------------
// LCP echo keepalive decision logic
// Maps one event word and the current keepalive state to a result word and
// the next state. Purely combinational.
// ----------------------------------------------------------------------------
module lcpek_decide import lcpek_pkg::*; (
  input  lcpek_in_t    word_i,
  input  lcpek_cfg_t   cfg_i,
  input  lcpek_state_t st_i,
  output lcpek_out_t   res_o,
  output lcpek_state_t st_o
);

  logic [31:0] idle_secs;
  logic        timeout_on;
  logic        rx_new;
  logic        recent;
  logic        loopback;

  // Wrap-safe idle time and suppression checks
  assign idle_secs  = word_i.now_seconds - st_i.last_activity_time;
  assign timeout_on = (cfg_i.echo_timeout != '0);
  assign rx_new     = (st_i.last_rx_count != word_i.rx_pkt_total);
  assign recent     = (idle_secs < {16'd0, cfg_i.echo_timeout});
  assign loopback   = word_i.reply_has_magic && (cfg_i.local_magic != '0) &&
                      (word_i.reply_magic == cfg_i.local_magic);

  // Event dispatch
  always_comb begin
    st_o  = st_i;
    res_o = '0;
    case (word_i.func)
      FUNC_TICK: begin
        if (timeout_on && rx_new) begin
          // fresh receive traffic: note it, no probe
          st_o.last_rx_count      = word_i.rx_pkt_total;
          st_o.last_activity_time = word_i.now_seconds;
          st_o.echoes_outstanding = '0;
        end else if (timeout_on && recent) begin
          res_o.action = ACT_NONE;
        end else if (st_i.echoes_outstanding > cfg_i.failure_limit) begin
          res_o.action = ACT_CARRIER_LOST;
        end else begin
          res_o.action    = ACT_ECHO_REQ;
          res_o.packet_id = st_i.next_id;
          res_o.magic_out = cfg_i.local_magic;
          st_o.next_id    = st_i.next_id + 8'd1;
          if (st_i.echoes_outstanding != OutstandingMax) begin
            st_o.echoes_outstanding = st_i.echoes_outstanding + 8'd1;
          end
        end
      end
      FUNC_ECHO_REP: begin
        st_o.echoes_outstanding = '0;
        st_o.last_activity_time = word_i.now_seconds;
        res_o.action            = loopback ? ACT_LOOPBACK : ACT_NONE;
      end
      FUNC_ECHO_REQ: begin
        st_o.echoes_outstanding = '0;
        st_o.last_activity_time = word_i.now_seconds;
        res_o.action            = ACT_ECHO_REP;
        res_o.packet_id         = word_i.request_id;
        res_o.magic_out         = cfg_i.local_magic;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/lcp_echo_keepalive.sv
// ----------------------------------------------------------------------------
// LCP echo keepalive
// PPP LCP echo keepalive and loop-back detector, one event word per cycle when not stalled.
// ----------------------------------------------------------------------------
// Each input word is one event (keepalive tick, echo reply or echo request)
// and yields exactly one result word: no action, send echo request, send echo
// reply, carrier lost, or loop-back. The block takes one word per cycle while
// in_stall_o is low. An accepted word waits in the input register, where the
// decision logic reads and updates the keepalive state, and its result loads
// the result register when that slot is free, so a following word always sees
// the state left by the one before. A stalled result holds the input register;
// with both registers full, in_stall_o rises until the result word is taken.
// The user must write configuration registers through the plain write port
// only while no word is in flight; the block itself does not enforce this.
`include "lcp_echo_keepalive_assert.svh"

module lcp_echo_keepalive import lcpek_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // event words
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lcpek_in_t           in_word_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lcpek_out_t          out_word_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  lcpek_cfg_t   cfg_q;
  lcpek_state_t st_q, st_d;
  lcpek_in_t    in_word_q;
  logic         in_valid_q;
  lcpek_out_t   res_d, out_word_q;
  logic         out_valid_q;
  logic         adv;
  logic         out_probe;
  logic         out_blank;
  logic [7:0]   outst;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.echo_timeout  <= EchoTimeoutRst;
      cfg_q.failure_limit <= FailureLimitRst;
      cfg_q.local_magic   <= LocalMagicRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ECHO_TIMEOUT:  cfg_q.echo_timeout  <= cfg_data_i[15:0];
        CFG_FAILURE_LIMIT: cfg_q.failure_limit <= cfg_data_i[7:0];
        CFG_LOCAL_MAGIC:   cfg_q.local_magic   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage handshake: the input register moves on when the result slot frees
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  // Decision logic
  lcpek_decide u_decide (
    .word_i (in_word_q),
    .cfg_i  (cfg_q),
    .st_i   (st_q),
    .res_o  (res_d),
    .st_o   (st_d)
  );

  // Keepalive state, updated as each word leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Assertion helpers
  assign out_probe = out_valid_q && (out_word_q.action == ACT_ECHO_REQ);
  assign out_blank = (out_word_q.action == ACT_NONE) ||
                     (out_word_q.action == ACT_CARRIER_LOST) ||
                     (out_word_q.action == ACT_LOOPBACK);
  assign outst     = st_q.echoes_outstanding;

  // Assertions
  `LCPEK_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !(out_valid_q || in_valid_q), "busy in reset")
  `LCPEK_ASSERT(a_in_held, in_stall_o |=> in_valid_q, "input word dropped while blocked")
  `LCPEK_ASSERT(a_id_on_probe, (st_q.next_id != $past(st_q.next_id)) |-> out_probe,
                "identifier moved without an echo request")
  `LCPEK_ASSERT(a_outst_step,
                (outst != $past(outst)) |-> ((outst == 8'd0) || (outst == $past(outst) + 8'd1)),
                "outstanding count jumped")
  `LCPEK_ASSERT(a_blank_fields,
                (out_valid_q && out_blank) |-> (out_word_q.packet_id == 8'd0 && out_word_q.magic_out == 32'd0),
                "unused result fields not zero")

endmodule
